// ===== rtl/ecgfbr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecgfbr_pkg
// Shared constants, register indexes and controller/datapath types for the
// ECG filter and heart-rate core.
// ----------------------------------------------------------------------------
package ecgfbr_pkg;

    localparam int SAMPLE_BITS      = 12;
    localparam int STATE_BITS       = 25;
    localparam int COEF_BITS        = 16;
    localparam int COEF_FRAC        = 14;
    localparam int GAIN_BITS        = 15;
    localparam int TIME_BITS        = 32;
    localparam int FILT_BITS        = 24;
    localparam int RATE_BITS        = 16;
    localparam int BPM_BITS         = 8;
    localparam int REARM_GAP        = 150;
    localparam int RATE_NUM         = 60000;
    localparam int DEF_AVG_DEPTH    = 5;
    localparam int DEF_FRAC_BITS    = 8;

    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 48;
    localparam int DIV_W   = 24;
    localparam int DEN_W   = TIME_BITS;
    localparam int STEP_W  = $clog2(DIV_W);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_OUTER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A_FIRST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A_SECOND  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LP_GAIN   = 3'd7;

    localparam logic signed [COEF_BITS-1:0] RST_THRESHOLD = 16'sd2400;
    localparam logic [COEF_BITS-1:0]        RST_MIN_INTV  = 16'd500;
    localparam logic signed [COEF_BITS-1:0] RST_B_OUTER   = 16'sd15386;
    localparam logic signed [COEF_BITS-1:0] RST_B_MIDDLE  = -16'sd24896;
    localparam logic signed [COEF_BITS-1:0] RST_A_FIRST   = -16'sd24896;
    localparam logic signed [COEF_BITS-1:0] RST_A_SECOND  = 16'sd14387;
    localparam logic [GAIN_BITS-1:0]        RST_HP_GAIN   = 15'd16281;
    localparam logic [GAIN_BITS-1:0]        RST_LP_GAIN   = 15'd9830;

    // multiplier operand selects, also the term counter of the controller
    localparam logic [2:0] SEL_B0_X   = 3'd0;
    localparam logic [2:0] SEL_B1_X1  = 3'd1;
    localparam logic [2:0] SEL_B0_X2  = 3'd2;
    localparam logic [2:0] SEL_A1_Y1  = 3'd3;
    localparam logic [2:0] SEL_A2_Y2  = 3'd4;
    localparam logic [2:0] SEL_HP     = 3'd5;
    localparam logic [2:0] SEL_LP_NEW = 3'd6;
    localparam logic [2:0] SEL_LP_OLD = 3'd7;

    typedef struct packed {
        logic       load_in;
        logic       mul;
        logic [2:0] sel;
        logic       acc_en;
        logic       acc_clr;
        logic       acc_neg;
        logic       rnd_notch;
        logic       rnd_hp;
        logic       rnd_lp;
        logic       detect;
        logic       div_start;
        logic       div_step;
        logic       avg_write;
        logic       finish;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic beat_go;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/ecgfbr_in_if.sv =====
// ----------------------------------------------------------------------------
// ecgfbr_in_if
// Sample request channel: lead-off flag, raw sample and timestamp.
// ----------------------------------------------------------------------------
interface ecgfbr_in_if;
    logic                               valid;
    logic                               ready;
    logic                               electrode_off;
    logic [ecgfbr_pkg::SAMPLE_BITS-1:0] sample;
    logic [ecgfbr_pkg::TIME_BITS-1:0]   now_ms;

    modport source (output valid, output electrode_off, output sample, output now_ms,
                    input ready);
    modport sink   (input valid, input electrode_off, input sample, input now_ms,
                    output ready);
endinterface

// ===== rtl/ecgfbr_out_if.sv =====
// ----------------------------------------------------------------------------
// ecgfbr_out_if
// Result request channel: echoed sample, filtered value and beat status.
// ----------------------------------------------------------------------------
interface ecgfbr_out_if;
    logic                                      valid;
    logic                                      ready;
    logic [ecgfbr_pkg::SAMPLE_BITS-1:0]        raw_echo;
    logic signed [ecgfbr_pkg::FILT_BITS-1:0]   filtered;
    logic [ecgfbr_pkg::BPM_BITS-1:0]           heart_rate;
    logic                                      electrode_off_out;
    logic                                      beat_indicator;
    logic                                      beat_event;

    modport source (output valid, output raw_echo, output filtered, output heart_rate,
                    output electrode_off_out, output beat_indicator, output beat_event,
                    input ready);
    modport sink   (input valid, input raw_echo, input filtered, input heart_rate,
                    input electrode_off_out, input beat_indicator, input beat_event,
                    output ready);
endinterface

// ===== rtl/ecg_filter_beat_rate_core.sv =====
// ----------------------------------------------------------------------------
// ecg_filter_beat_rate_core
// ECG notch/high-pass/low-pass filter with beat detection and averaged bpm.
//
// samples carries one request per ECG sample (lead-off flag, 12-bit reading,
// millisecond time); results returns one request for each of them, in order.
// The wr_* port writes one configuration register per cycle; the user must
// write it only while idle, as the block itself does not enforce this.
// One sample is in work at a time. A lead-off sample skips all arithmetic
// and goes to the result load; a normal sample first takes eight multiply
// and accumulate pairs on the shared multiplier, three rounding steps and
// the beat check. A counted beat adds divider set-up, the 24-step serial
// divider for the rate, the average update and the bpm scaling by a
// reciprocal multiply before the result load.
// samples.ready is high only while the sequencer waits for a sample. The
// result register holds a finished request until results.ready; a further
// sample is computed meanwhile and waits for the register to free up.
// Reset clears filter state, beat history and the average, and loads the
// register defaults.
// ----------------------------------------------------------------------------
module ecg_filter_beat_rate_core #(
    parameter int AVG_DEPTH       = ecgfbr_pkg::DEF_AVG_DEPTH,
    parameter int STATE_FRAC_BITS = ecgfbr_pkg::DEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [ecgfbr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ecgfbr_pkg::CFG_W-1:0]     wr_data,
    ecgfbr_in_if.sink                        samples,
    ecgfbr_out_if.source                     results
);
    import ecgfbr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ecgfbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_off   (samples.electrode_off),
        .in_ready (samples.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ecgfbr_datapath #(
        .AVG_DEPTH       (AVG_DEPTH),
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .in_electrode_off (samples.electrode_off),
        .in_sample        (samples.sample),
        .in_now_ms        (samples.now_ms),
        .results          (results)
    );

endmodule

// ===== rtl/ecgfbr_datapath.sv =====
// ----------------------------------------------------------------------------
// ecgfbr_datapath
// Filter state, shared multiply-accumulate, serial divider, rate average and
// result register.
// ----------------------------------------------------------------------------
module ecgfbr_datapath #(
    parameter int AVG_DEPTH       = ecgfbr_pkg::DEF_AVG_DEPTH,
    parameter int STATE_FRAC_BITS = ecgfbr_pkg::DEF_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ecgfbr_pkg::cmd_t                      cmd,
    output ecgfbr_pkg::sts_t                      sts,
    input  logic                                  wr_en,
    input  logic [ecgfbr_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [ecgfbr_pkg::CFG_W-1:0]          wr_data,
    input  logic                                  in_electrode_off,
    input  logic [ecgfbr_pkg::SAMPLE_BITS-1:0]    in_sample,
    input  logic [ecgfbr_pkg::TIME_BITS-1:0]      in_now_ms,
    ecgfbr_out_if.source                          results
);
    import ecgfbr_pkg::*;

    localparam int XW     = (SAMPLE_BITS + STATE_FRAC_BITS + 1 > STATE_BITS + 1) ?
                            SAMPLE_BITS + STATE_FRAC_BITS + 1 : STATE_BITS + 1;
    localparam int CMP_W  = 40;
    localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W  = RATE_BITS + $clog2(AVG_DEPTH + 1);
    localparam logic [DIV_W-1:0] RATE_Q = DIV_W'(RATE_NUM * 256);
    localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'((64'sd1 <<< (STATE_BITS-1)) - 1);
    localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);
    localparam logic signed [XW-1:0] X_MAX = XW'((64'sd1 <<< (STATE_BITS-1)) - 1);
    localparam logic signed [STATE_BITS-1:0] F_MAX = STATE_BITS'((1 <<< (FILT_BITS-1)) - 1);
    localparam logic signed [STATE_BITS-1:0] F_MIN = -F_MAX - STATE_BITS'(1);
    // average by reciprocal multiplication, exact over the whole sum range
    localparam int AVG_IN_W = SUM_W - 8;
    localparam int RECIP_SH = 18;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + AVG_DEPTH - 1) / AVG_DEPTH);
    localparam int AVGP_W   = AVG_IN_W + RECIP_W;

    // configuration
    logic signed [COEF_BITS-1:0] thr_reg, b0_reg, b1_reg, a1_reg, a2_reg;
    logic [COEF_BITS-1:0]        min_intv_reg;
    logic [GAIN_BITS-1:0]        hp_gain_reg, lp_gain_reg;

    // filter and detector state
    logic signed [STATE_BITS-1:0] x_reg, in1_reg, in2_reg, out1_reg, out2_reg;
    logic signed [STATE_BITS-1:0] hp_in_reg, hp_out_reg, lp_out_reg;
    logic                         latched_reg, ind_reg, event_reg;
    logic [TIME_BITS-1:0]         last_beat_reg, now_reg, dur_reg;
    logic [RATE_BITS-1:0]         hist_reg [AVG_DEPTH];
    logic [SLOT_W-1:0]            slot_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [BPM_BITS-1:0]          rate_held_reg;
    logic [SAMPLE_BITS-1:0]       raw_reg;
    logic                         off_reg;

    // arithmetic
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DIV_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic                     out_valid_reg;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [ACC_W-1:0]   term, rnd_sum, rnd_sh;
    logic signed [STATE_BITS-1:0] rnd;
    logic signed [XW-1:0]      x_wide;
    logic signed [STATE_BITS-1:0] x_sat;
    logic signed [CMP_W-1:0]   thr_c, rearm_c, lp_c;
    logic [TIME_BITS-1:0]      dur;
    logic                      above, below;
    logic [DEN_W:0]            rem_sh;
    logic                      q_bit;
    logic [RATE_BITS-1:0]      rate_q;
    logic signed [STATE_BITS-1:0] filt_sat;
    logic [AVGP_W-1:0]         avg_prod;

    function automatic logic signed [MUL_A_W-1:0] ext_s(input logic signed [STATE_BITS-1:0] v);
        return {{(MUL_A_W-STATE_BITS){v[STATE_BITS-1]}}, v};
    endfunction

    always_comb
    begin
        op_a = ext_s(x_sat);
        op_b = {b0_reg[COEF_BITS-1], b0_reg};
        case (cmd.sel)
            SEL_B0_X:   begin op_a = ext_s(x_sat);   op_b = {b0_reg[COEF_BITS-1], b0_reg}; end
            SEL_B1_X1:  begin op_a = ext_s(in1_reg); op_b = {b1_reg[COEF_BITS-1], b1_reg}; end
            SEL_B0_X2:  begin op_a = ext_s(in2_reg); op_b = {b0_reg[COEF_BITS-1], b0_reg}; end
            SEL_A1_Y1:  begin op_a = ext_s(out1_reg); op_b = {a1_reg[COEF_BITS-1], a1_reg}; end
            SEL_A2_Y2:  begin op_a = ext_s(out2_reg); op_b = {a2_reg[COEF_BITS-1], a2_reg}; end
            SEL_HP:
            begin
                op_a = ext_s(hp_out_reg) + ext_s(out1_reg) - ext_s(hp_in_reg);
                op_b = {2'b00, hp_gain_reg};
            end
            SEL_LP_NEW: begin op_a = ext_s(hp_out_reg); op_b = {2'b00, lp_gain_reg}; end
            SEL_LP_OLD:
            begin
                op_a = ext_s(lp_out_reg);
                op_b = 17'sd16384 - $signed({2'b00, lp_gain_reg});
            end
            default: ;
        endcase
    end

    always_comb
    begin
        term    = cmd.acc_neg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
        rnd_sum = acc_reg + ACC_W'(1 <<< (COEF_FRAC-1));
        rnd_sh  = rnd_sum >>> COEF_FRAC;
        if (rnd_sh > S_MAX)
            rnd = S_MAX[STATE_BITS-1:0];
        else if (rnd_sh < S_MIN)
            rnd = S_MIN[STATE_BITS-1:0];
        else
            rnd = rnd_sh[STATE_BITS-1:0];

        x_wide = $signed(XW'(raw_reg)) <<< STATE_FRAC_BITS;
        x_sat  = (x_wide > X_MAX) ? X_MAX[STATE_BITS-1:0] : x_wide[STATE_BITS-1:0];

        thr_c   = CMP_W'(thr_reg) <<< STATE_FRAC_BITS;
        rearm_c = (CMP_W'(thr_reg) - CMP_W'(REARM_GAP)) <<< STATE_FRAC_BITS;
        lp_c    = CMP_W'(lp_out_reg);
        above   = (lp_c > thr_c) && !latched_reg;
        below   = lp_c < rearm_c;
        dur     = now_reg - last_beat_reg;

        rem_sh = {rem_reg, num_reg[DIV_W-1]};
        q_bit  = rem_sh >= {1'b0, den_reg};
        rate_q = (num_reg > DIV_W'(16'hFFFF)) ? 16'hFFFF : num_reg[RATE_BITS-1:0];

        avg_prod = AVGP_W'(sum_reg[SUM_W-1:8]) * AVGP_W'(RECIP);

        if (lp_out_reg > F_MAX)
            filt_sat = F_MAX;
        else if (lp_out_reg < F_MIN)
            filt_sat = F_MIN;
        else
            filt_sat = lp_out_reg;
    end

    assign sts.beat_go  = above && (dur > TIME_BITS'(min_intv_reg));
    assign sts.out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= RST_THRESHOLD;
            min_intv_reg <= RST_MIN_INTV;
            b0_reg       <= RST_B_OUTER;
            b1_reg       <= RST_B_MIDDLE;
            a1_reg       <= RST_A_FIRST;
            a2_reg       <= RST_A_SECOND;
            hp_gain_reg  <= RST_HP_GAIN;
            lp_gain_reg  <= RST_LP_GAIN;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_THRESHOLD: thr_reg      <= wr_data;
                REG_MIN_INTV:  min_intv_reg <= wr_data;
                REG_B_OUTER:   b0_reg       <= wr_data;
                REG_B_MIDDLE:  b1_reg       <= wr_data;
                REG_A_FIRST:   a1_reg       <= wr_data;
                REG_A_SECOND:  a2_reg       <= wr_data;
                REG_HP_GAIN:   hp_gain_reg  <= wr_data[GAIN_BITS-1:0];
                REG_LP_GAIN:   lp_gain_reg  <= wr_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            in1_reg       <= '0;
            in2_reg       <= '0;
            out1_reg      <= '0;
            out2_reg      <= '0;
            hp_in_reg     <= '0;
            hp_out_reg    <= '0;
            lp_out_reg    <= '0;
            latched_reg   <= 1'b0;
            ind_reg       <= 1'b0;
            event_reg     <= 1'b0;
            last_beat_reg <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            rate_held_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AVG_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                event_reg <= 1'b0;
                if (in_electrode_off)
                begin
                    rate_held_reg <= '0;
                    ind_reg       <= 1'b1;
                end
            end
            if (cmd.mul)
                x_reg <= x_sat;
            if (cmd.rnd_notch)
            begin
                in1_reg  <= x_reg;
                in2_reg  <= in1_reg;
                out1_reg <= rnd;
                out2_reg <= out1_reg;
            end
            if (cmd.rnd_hp)
            begin
                hp_out_reg <= rnd;
                hp_in_reg  <= out1_reg;
            end
            if (cmd.rnd_lp)
                lp_out_reg <= rnd;
            if (cmd.detect)
            begin
                if (above)
                    latched_reg <= 1'b1;
                else if (below)
                begin
                    latched_reg <= 1'b0;
                    ind_reg     <= 1'b0;
                end
            end
            if (cmd.avg_write)
            begin
                hist_reg[slot_reg] <= rate_q;
                sum_reg  <= sum_reg - SUM_W'(hist_reg[slot_reg]) + SUM_W'(rate_q);
                slot_reg <= (slot_reg == SLOT_W'(AVG_DEPTH-1)) ? '0 : slot_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                rate_held_reg <= (|avg_prod[AVGP_W-1:RECIP_SH+BPM_BITS]) ? 8'hFF :
                                 avg_prod[RECIP_SH+BPM_BITS-1:RECIP_SH];
                last_beat_reg <= now_reg;
                ind_reg       <= 1'b1;
                event_reg     <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_reg <= in_sample;
            off_reg <= in_electrode_off;
            now_reg <= in_now_ms;
        end
        if (cmd.mul)
            prod_reg <= op_a * op_b;
        if (cmd.acc_en)
            acc_reg <= cmd.acc_clr ? term : acc_reg + term;
        if (cmd.detect)
            dur_reg <= dur;
        if (cmd.div_start)
        begin
            num_reg <= RATE_Q;
            den_reg <= dur_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            num_reg <= {num_reg[DIV_W-2:0], q_bit};
        end
        if (cmd.out_load)
        begin
            results.raw_echo          <= off_reg ? '0 : raw_reg;
            results.filtered          <= filt_sat[FILT_BITS-1:0];
            results.heart_rate        <= rate_held_reg;
            results.electrode_off_out <= off_reg;
            results.beat_indicator    <= ind_reg;
            results.beat_event        <= event_reg;
        end
    end

    assign results.valid = out_valid_reg;

endmodule

// ===== rtl/ecgfbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecgfbr_ctrl
// Sequencer for one sample: filter terms, rounding, beat check, rate
// division and averaging, result hand-off.
// ----------------------------------------------------------------------------
module ecgfbr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_off,
    output logic             in_ready,
    output ecgfbr_pkg::cmd_t cmd,
    input  ecgfbr_pkg::sts_t sts
);
    import ecgfbr_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL       = 4'd1;
    localparam logic [3:0] S_ACC       = 4'd2;
    localparam logic [3:0] S_RND       = 4'd3;
    localparam logic [3:0] S_DETECT    = 4'd4;
    localparam logic [3:0] S_DIV_START = 4'd5;
    localparam logic [3:0] S_DIV_RUN   = 4'd6;
    localparam logic [3:0] S_AVG       = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;
    localparam logic [3:0] S_WAIT_OUT  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [2:0]        term_reg, term_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.sel    = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    term_next   = SEL_B0_X;
                    state_next  = in_off ? S_WAIT_OUT : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en  = 1'b1;
                cmd.acc_clr = (term_reg == SEL_B0_X) || (term_reg == SEL_HP) ||
                              (term_reg == SEL_LP_NEW);
                cmd.acc_neg = (term_reg == SEL_A1_Y1) || (term_reg == SEL_A2_Y2);
                if ((term_reg == SEL_A2_Y2) || (term_reg == SEL_HP) ||
                    (term_reg == SEL_LP_OLD))
                    state_next = S_RND;
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = S_MUL;
                end
            end
            S_RND:
            begin
                cmd.rnd_notch = (term_reg == SEL_A2_Y2);
                cmd.rnd_hp    = (term_reg == SEL_HP);
                cmd.rnd_lp    = (term_reg == SEL_LP_OLD);
                if (term_reg == SEL_LP_OLD)
                    state_next = S_DETECT;
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = S_MUL;
                end
            end
            S_DETECT:
            begin
                cmd.detect = 1'b1;
                state_next = sts.beat_go ? S_DIV_START : S_WAIT_OUT;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_W-1))
                    state_next = S_AVG;
                else
                    step_next = step_reg + 1'b1;
            end
            S_AVG:
            begin
                cmd.avg_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_WAIT_OUT;
            end
            S_WAIT_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            step_reg  <= step_next;
        end
    end

endmodule
